>>> rtl/swmm_pkg.sv
package swmm_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int FILL_W      = 10;
    localparam int WINDOW_DEF  = 512;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic                vld;
        logic [SAMPLE_W-1:0] sample;
    } t_q_item;

endpackage

>>> rtl/swmm_front.sv
module swmm_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [swmm_pkg::SAMPLE_W-1:0]       i_frame_time_us,
    output swmm_pkg::t_q_item                   o_q,
    input  logic                                i_q_take
);

    localparam int DEPTH = swmm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [swmm_pkg::SAMPLE_W-1:0] r_buf [DEPTH];
    logic [PTR_W-1:0]              r_wr_ptr;
    logic [PTR_W-1:0]              r_rd_ptr;
    logic [LVL_W-1:0]              r_level;
    logic                          w_push;
    logic                          w_pop;

    assign o_stall  = (r_level == LVL_W'(DEPTH));
    assign w_push   = i_valid && !o_stall;
    assign w_pop    = o_q.vld && i_q_take;
    assign o_q.vld    = (r_level != '0);
    assign o_q.sample = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= i_frame_time_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_level <= r_level + LVL_W'(1);
            end else if (w_pop && !w_push) begin
                r_level <= r_level - LVL_W'(1);
            end
        end
    end

endmodule

>>> rtl/swmm_div.sv
module swmm_div #(
    parameter int WINDOW = swmm_pkg::WINDOW_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_start,
    input  logic [swmm_pkg::SAMPLE_W+$clog2(WINDOW+1)-1:0]    i_dividend,
    input  logic [$clog2(WINDOW+1)-1:0]                       i_divisor,
    output logic                                              o_done,
    output logic [swmm_pkg::SAMPLE_W+$clog2(WINDOW+1)-1:0]    o_quotient
);

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = swmm_pkg::SAMPLE_W + CNT_W;
    localparam int STEP_W = $clog2(SUM_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_step;
    logic [SUM_W-1:0]   r_dvd;
    logic [CNT_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_dvs;
    logic [CNT_W:0]     w_trial;
    logic [CNT_W:0]     w_diff;
    logic               w_ge;

    // restoring divide, one quotient bit per cycle shifted into the dividend
    assign w_trial = {r_rem, r_dvd[SUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W);
                r_dvd  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_dvd  <= {r_dvd[SUM_W-2:0], w_ge};
                r_rem  <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/swmm_back.sv
module swmm_back #(
    parameter int WINDOW = swmm_pkg::WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  swmm_pkg::t_q_item                   i_q,
    output logic                                o_q_take,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [swmm_pkg::SAMPLE_W-1:0]       o_min_time_us,
    output logic [swmm_pkg::SAMPLE_W-1:0]       o_max_time_us,
    output logic [swmm_pkg::SAMPLE_W-1:0]       o_mean_time_us,
    output logic [swmm_pkg::FILL_W-1:0]         o_fill_count
);

    localparam int SAMPLE_W = swmm_pkg::SAMPLE_W;
    localparam int IDX_W    = $clog2(WINDOW);
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int SUM_W    = SAMPLE_W + CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_DSTART,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state               r_state;
    logic [SAMPLE_W-1:0]  r_ring [WINDOW];
    logic [SAMPLE_W-1:0]  r_rd_data;
    logic                 r_rd_vld;
    logic [SAMPLE_W-1:0]  r_sample;
    logic [IDX_W-1:0]     r_slot;
    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_idx;
    logic [SAMPLE_W-1:0]  r_lo;
    logic [SAMPLE_W-1:0]  r_hi;
    logic [SUM_W-1:0]     r_sum;
    logic                 r_o_valid;
    logic [SAMPLE_W-1:0]  r_o_min;
    logic [SAMPLE_W-1:0]  r_o_max;
    logic [SAMPLE_W-1:0]  r_o_mean;
    logic [CNT_W-1:0]     r_o_count;
    logic                 w_div_done;
    logic [SUM_W-1:0]     w_quot;
    logic                 w_last_idx;

    assign o_q_take   = (r_state == ST_IDLE) && i_q.vld;
    assign w_last_idx = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    assign o_valid        = r_o_valid;
    assign o_min_time_us  = r_o_min;
    assign o_max_time_us  = r_o_max;
    assign o_mean_time_us = r_o_mean;
    assign o_fill_count   = swmm_pkg::FILL_W'(r_o_count);

    swmm_div #(
        .WINDOW (WINDOW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_DSTART),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // sample ring, at most one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE) begin
            r_ring[r_slot] <= r_sample;
        end
        r_rd_data <= r_ring[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_slot    <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == ST_SCAN);
            if (r_rd_vld) begin
                if (r_rd_data < r_lo) begin
                    r_lo <= r_rd_data;
                end
                if (r_rd_data > r_hi) begin
                    r_hi <= r_rd_data;
                end
                r_sum <= r_sum + SUM_W'(r_rd_data);
            end
            if (r_o_valid && !i_stall && (r_state != ST_OUT)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q.vld) begin
                        r_sample <= i_q.sample;
                        r_state  <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    r_slot  <= (r_slot == IDX_W'(WINDOW - 1)) ? '0 : r_slot + IDX_W'(1);
                    if (r_count != CNT_W'(WINDOW)) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_lo    <= r_sample;
                    r_hi    <= r_sample;
                    r_sum   <= '0;
                    r_idx   <= '0;
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (w_last_idx) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                ST_DRAIN: begin
                    // last read lands in the accumulators at this edge
                    r_state <= ST_DSTART;
                end
                ST_DSTART: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid <= 1'b1;
                        r_o_min   <= r_lo;
                        r_o_max   <= r_hi;
                        r_o_mean  <= w_quot[SAMPLE_W-1:0];
                        r_o_count <= r_count;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/sliding_window_min_max_mean.sv
// channel   valid     stall     payload
// input     i_valid   o_stall   i_frame_time_us
// output    o_valid   i_stall   o_min_time_us, o_max_time_us, o_mean_time_us, o_fill_count
//
// each item is handled in turn by a one-read-per-cycle scan of the sample ring
// and a one-bit-per-cycle divider for the mean over SUM_W = 24 + clog2(WINDOW+1)
// bits; the back end takes no new item until the last result is registered
// a two-item queue takes input while the back end works or its result waits
// reset is synchronous and active low; the ring itself is not cleared
module sliding_window_min_max_mean #(
    parameter int WINDOW = swmm_pkg::WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [swmm_pkg::SAMPLE_W-1:0]       i_frame_time_us,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [swmm_pkg::SAMPLE_W-1:0]       o_min_time_us,
    output logic [swmm_pkg::SAMPLE_W-1:0]       o_max_time_us,
    output logic [swmm_pkg::SAMPLE_W-1:0]       o_mean_time_us,
    output logic [swmm_pkg::FILL_W-1:0]         o_fill_count
);

    swmm_pkg::t_q_item w_q;
    logic              w_q_take;

    swmm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_frame_time_us (i_frame_time_us),
        .o_q             (w_q),
        .i_q_take        (w_q_take)
    );

    swmm_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q            (w_q),
        .o_q_take       (w_q_take),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_min_time_us  (o_min_time_us),
        .o_max_time_us  (o_max_time_us),
        .o_mean_time_us (o_mean_time_us),
        .o_fill_count   (o_fill_count)
    );

`ifndef SYNTHESIS
    a_mean_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_min_time_us <= o_mean_time_us) && (o_mean_time_us <= o_max_time_us))
        else $error("mean outside min/max");

    a_stall_means_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> w_q.vld)
        else $error("input stalled with empty queue");

    a_take_only_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_take |-> w_q.vld)
        else $error("back end took from empty queue");
`endif

endmodule
